// ===== design/tmprof_pkg.sv =====
// Shared types, codes and helper functions of the trapezoid motion profile generator.
package tmprof_pkg;

    localparam int TICK_HZ_DEF = 100;
    localparam int QDEPTH = 2;

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_STOP  = 2'd2;

    localparam logic [1:0] PH_STOP   = 2'd0;
    localparam logic [1:0] PH_ACCEL  = 2'd1;
    localparam logic [1:0] PH_CRUISE = 2'd2;
    localparam logic [1:0] PH_DECEL  = 2'd3;

    localparam logic [1:0] CFG_ACCEL = 2'd0;
    localparam logic [1:0] CFG_DECEL = 2'd1;
    localparam logic [1:0] CFG_ARC   = 2'd2;

    localparam logic [23:0] TICKS_MAX = 24'hFFFFFF;

    typedef enum logic [1:0] {
        KIND_TICK,
        KIND_START,
        KIND_STOP,
        KIND_NOP
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic signed [15:0] distance;
        logic [11:0]        max_speed;
        logic               rotate;
    } item_t;

    // Head of the command queue as seen by the execution side.
    typedef struct packed {
        logic  valid;
        item_t item;
    } qhead_t;

    typedef struct packed {
        logic [15:0] accel;
        logic [15:0] decel;
        logic [15:0] arc;
    } cfg_t;

    typedef struct packed {
        logic signed [23:0] left;
        logic signed [23:0] right;
        logic [11:0]        speed;
    } emit_t;

    // A zero rate is treated as one.
    function automatic logic [15:0] nz16(input logic [15:0] v);
        return (v == 16'd0) ? 16'd1 : v;
    endfunction

    // Wheel setpoints and displayed speed from the travel and speed accumulators.
    function automatic emit_t emit(input logic signed [39:0] trv,
                                   input logic signed [31:0] spd,
                                   input logic turn,
                                   input logic rev);
        logic signed [31:0] s;
        logic signed [23:0] m;
        logic signed [23:0] l;
        logic signed [23:0] r;
        emit_t              e;
        s = trv[39:8];
        if (s > 32'sd8388607)
        begin
            m = 24'sd8388607;
        end
        else if (s < -32'sd8388607)
        begin
            m = -24'sd8388607;
        end
        else
        begin
            m = s[23:0];
        end
        l = turn ? -m : m;
        r = m;
        if (rev)
        begin
            l = -l;
            r = -r;
        end
        e.left  = l;
        e.right = r;
        if (spd <= 32'sd0)
        begin
            e.speed = 12'd0;
        end
        else if (spd[31:16] > 16'd4095)
        begin
            e.speed = 12'd4095;
        end
        else
        begin
            e.speed = spd[27:16];
        end
        return e;
    endfunction

endpackage

// ===== design/tmprof_front.sv =====
// Command intake: accepts items, classifies the opcode and queues them for execution.
module tmprof_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  logic [1:0]          opcode,
    input  logic signed [15:0]  distance,
    input  logic [11:0]         max_speed_mm_s,
    input  logic                rotate,
    output tmprof_pkg::qhead_t  head,
    input  logic                head_pop
);
    import tmprof_pkg::*;

    localparam int PW = $clog2(QDEPTH);

    item_t          mem_reg [QDEPTH];
    logic [PW-1:0]  wr_ptr_reg;
    logic [PW-1:0]  rd_ptr_reg;
    logic [PW:0]    count_reg;
    item_t          item_in;
    logic           do_push;
    logic           do_pop;

    // Classify the opcode into a command kind.
    always_comb
    begin
        item_in.distance  = distance;
        item_in.max_speed = max_speed_mm_s;
        item_in.rotate    = rotate;
        unique case (opcode)
            OP_TICK:  item_in.kind = KIND_TICK;
            OP_START: item_in.kind = KIND_START;
            OP_STOP:  item_in.kind = KIND_STOP;
            default:  item_in.kind = KIND_NOP;
        endcase
    end

    assign full       = (count_reg == (PW+1)'(QDEPTH));
    assign do_push    = push && !full;
    assign do_pop     = head_pop && head.valid;
    assign head.valid = (count_reg != '0);
    assign head.item  = mem_reg[rd_ptr_reg];

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= item_in;
        end
    end

    // Queue pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== design/tmprof_div.sv =====
// Restoring divider, one quotient bit per cycle, 64-bit dividend by 32-bit divisor.
module tmprof_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [63:0] quotient
);
    logic [63:0] quo_reg;
    logic [31:0] rem_reg;
    logic [31:0] div_reg;
    logic [6:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [32:0] shifted;
    logic [32:0] diff;
    logic        ge;

    // One trial subtraction per cycle.
    always_comb
    begin
        shifted = {rem_reg, quo_reg[63]};
        diff    = shifted - {1'b0, div_reg};
        ge      = (shifted >= {1'b0, div_reg});
    end

    // Datapath.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[62:0], ge};
            rem_reg <= ge ? diff[31:0] : shifted[31:0];
        end
    end

    // Iteration control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= 7'd64;
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== design/tmprof_sqrt.sv =====
// Digit-by-digit integer square root of a 64-bit value, one result bit per cycle.
module tmprof_sqrt (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] radicand,
    output logic        done,
    output logic [31:0] root
);
    logic [63:0] x_reg;
    logic [63:0] r_reg;
    logic [63:0] bit_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [63:0] sum;
    logic        ge;

    always_comb
    begin
        sum = r_reg + bit_reg;
        ge  = (x_reg >= sum);
    end

    // Datapath.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg   <= radicand;
            r_reg   <= '0;
            bit_reg <= 64'd1 << 62;
        end
        else if (busy_reg)
        begin
            if (ge)
            begin
                x_reg <= x_reg - sum;
                r_reg <= (r_reg >> 1) + bit_reg;
            end
            else
            begin
                r_reg <= r_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    // Runs until the trial bit has passed the lowest position.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            if (bit_reg == 64'd1)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    assign done = done_reg;
    assign root = r_reg[31:0];

endmodule

// ===== design/tmprof_back.sv =====
// Execution side: move planning, per-tick profile update and the result register.
module tmprof_back #(
    parameter int TICK_HZ = tmprof_pkg::TICK_HZ_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  tmprof_pkg::cfg_t    cfg,
    input  tmprof_pkg::qhead_t  head,
    output logic                head_pop,
    output logic                empty,
    input  logic                pop,
    output logic signed [23:0]  left_setpoint,
    output logic signed [23:0]  right_setpoint,
    output logic [1:0]          phase,
    output logic [11:0]         speed_now,
    output logic                move_done
);
    import tmprof_pkg::*;

    localparam logic [63:0] TH64   = 64'(TICK_HZ);
    localparam logic [31:0] HALF32 = 32'(TICK_HZ / 2);

    // Reciprocal of the tick rate; exact for every 32-bit dividend.
    localparam int          RS    = 32 + $clog2(TICK_HZ);
    localparam logic [32:0] RECIP = 33'(((64'd1 << RS) + 64'(TICK_HZ) - 64'd1) /
                                        64'(TICK_HZ));

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_LEN  = 5'd1;
    localparam logic [4:0] S_R1   = 5'd2;
    localparam logic [4:0] S_R2   = 5'd3;
    localparam logic [4:0] S_CMP  = 5'd4;
    localparam logic [4:0] S_T1   = 5'd5;
    localparam logic [4:0] S_T2   = 5'd6;
    localparam logic [4:0] S_T3   = 5'd7;
    localparam logic [4:0] S_M1   = 5'd8;
    localparam logic [4:0] S_M2   = 5'd9;
    localparam logic [4:0] S_Q    = 5'd10;
    localparam logic [4:0] S_SQ   = 5'd11;
    localparam logic [4:0] S_A    = 5'd12;
    localparam logic [4:0] S_D    = 5'd13;
    localparam logic [4:0] S_SPD  = 5'd14;
    localparam logic [4:0] S_TRV  = 5'd15;
    localparam logic [4:0] S_FIN  = 5'd16;

    logic [4:0]         state_reg;
    logic               issued_reg;
    item_t              item_reg;

    // Profile state.
    logic [1:0]         phase_reg;
    logic signed [31:0] speed_reg;
    logic signed [39:0] travel_reg;
    logic [23:0]        accel_ticks_reg;
    logic [23:0]        cruise_ticks_reg;
    logic [23:0]        decel_ticks_reg;
    logic [23:0]        count_reg;
    logic               tri_reg;
    logic               rev_reg;
    logic               turn_reg;

    // Planning work registers.
    logic [15:0]        a_reg;
    logic [15:0]        d_reg;
    logic [11:0]        v_reg;
    logic [31:0]        len_reg;
    logic [39:0]        v2_reg;
    logic [40:0]        ramp_reg;
    logic [63:0]        prod_reg;
    logic [31:0]        vp_reg;

    // Low half product of the tick-rate reciprocal multiply.
    logic [48:0]        rm_lo_reg;

    // Result register.
    logic               out_valid_reg;
    emit_t              out_emit_reg;
    logic [1:0]         out_phase_reg;
    logic               out_done_reg;

    // Shared units.
    logic               div_start;
    logic [63:0]        div_dividend;
    logic [31:0]        div_divisor;
    logic               div_done;
    logic [63:0]        div_q;
    logic               sq_start;
    logic               sq_done;
    logic [31:0]        sq_root;

    logic [15:0]        mag;
    logic [15:0]        rate;
    logic [31:0]        spd_mag;
    logic [31:0]        len_left;
    logic [23:0]        q_sat;
    logic [31:0]        rm_x;
    logic [15:0]        rm_half;
    logic [48:0]        rm_prod;
    logic [64:0]        rm_sum;
    logic [31:0]        rq;
    logic signed [33:0] spd_sum;
    logic signed [31:0] spd_new;
    logic signed [40:0] trv_step;
    logic signed [40:0] trv_sum;
    logic signed [39:0] trv_new;
    logic [63:0]        prod_full;

    logic [1:0]         fin_phase;
    logic [23:0]        fin_count;
    logic [23:0]        cnt_inc;
    logic               fin_done;
    logic               fin_clear;
    logic signed [39:0] em_trv;
    logic signed [31:0] em_spd;
    emit_t              em;
    logic               out_free;

    tmprof_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    tmprof_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sq_start),
        .radicand ({prod_reg[47:0], 16'd0}),
        .done     (sq_done),
        .root     (sq_root)
    );

    // Operand preparation and saturation helpers.
    always_comb
    begin
        mag       = item_reg.distance[15] ? 16'(-item_reg.distance) : item_reg.distance;
        rate      = (phase_reg == PH_ACCEL) ? nz16(cfg.accel) : nz16(cfg.decel);
        spd_mag   = speed_reg[31] ? 32'(-speed_reg) : speed_reg;
        len_left  = len_reg - ramp_reg[31:0];
        q_sat     = (div_q[63:24] != '0) ? TICKS_MAX : div_q[23:0];
        prod_full = prod_reg[47:0] * d_reg;

        // Division by the tick rate as a reciprocal multiply, one 16-bit half per cycle.
        rm_x    = (state_reg == S_SPD) ? ({rate, 16'd0} + HALF32) : (spd_mag + HALF32);
        rm_half = issued_reg ? rm_x[31:16] : rm_x[15:0];
        rm_prod = {33'd0, rm_half} * {16'd0, RECIP};
        rm_sum  = {16'd0, rm_lo_reg} + {rm_prod, 16'd0};
        rq      = 32'(rm_sum >> RS);

        if (phase_reg == PH_ACCEL)
        begin
            spd_sum = {{2{speed_reg[31]}}, speed_reg} + {2'b00, rq};
        end
        else
        begin
            spd_sum = {{2{speed_reg[31]}}, speed_reg} - {2'b00, rq};
        end
        if (spd_sum[33:31] == 3'b000 || spd_sum[33:31] == 3'b111)
        begin
            spd_new = spd_sum[31:0];
        end
        else
        begin
            spd_new = spd_sum[33] ? 32'sh80000000 : 32'sh7FFFFFFF;
        end
        trv_step = speed_reg[31] ? -{9'd0, rq} : {9'd0, rq};
        trv_sum  = {travel_reg[39], travel_reg} + trv_step;
        if (trv_sum[40] == trv_sum[39])
        begin
            trv_new = trv_sum[39:0];
        end
        else
        begin
            trv_new = trv_sum[40] ? {1'b1, 39'd0} : {1'b0, {39{1'b1}}};
        end
    end

    // Divider operands for each dividing step.
    always_comb
    begin
        div_dividend = '0;
        div_divisor  = 32'd1;
        case (state_reg)
            S_R1:
            begin
                div_dividend = {24'd0, v2_reg};
                div_divisor  = {15'd0, a_reg, 1'b0};
            end
            S_R2:
            begin
                div_dividend = {24'd0, v2_reg};
                div_divisor  = {15'd0, d_reg, 1'b0};
            end
            S_T1:
            begin
                div_dividend = 64'(v_reg) * TH64 + 64'(a_reg) - 64'd1;
                div_divisor  = 32'(a_reg);
            end
            S_T2:
            begin
                div_dividend = 64'(v_reg) * TH64 + 64'(d_reg) - 64'd1;
                div_divisor  = 32'(d_reg);
            end
            S_T3:
            begin
                div_dividend = 64'(len_left) * TH64 + {36'd0, v_reg, 16'd0} - 64'd1;
                div_divisor  = {4'd0, v_reg, 16'd0};
            end
            S_Q:
            begin
                div_dividend = prod_reg;
                div_divisor  = 32'(a_reg) + 32'(d_reg);
            end
            S_A:
            begin
                div_dividend = 64'(vp_reg) * TH64 + {32'd0, a_reg, 16'd0} - 64'd1;
                div_divisor  = {a_reg, 16'd0};
            end
            S_D:
            begin
                div_dividend = 64'(vp_reg) * TH64 + {32'd0, d_reg, 16'd0} - 64'd1;
                div_divisor  = {d_reg, 16'd0};
            end
            default:
            begin
                div_dividend = '0;
            end
        endcase
    end

    assign div_start = !issued_reg && (state_reg == S_R1 || state_reg == S_R2 ||
                       state_reg == S_T1 || state_reg == S_T2 || state_reg == S_T3 ||
                       state_reg == S_Q || state_reg == S_A || state_reg == S_D);
    assign sq_start  = !issued_reg && (state_reg == S_SQ);
    assign head_pop  = (state_reg == S_IDLE) && head.valid;
    assign out_free  = !out_valid_reg || pop;

    // Final phase, counter and shown values of the item being finished.
    always_comb
    begin
        fin_phase = phase_reg;
        fin_count = count_reg;
        fin_done  = 1'b0;
        fin_clear = 1'b0;
        em_trv    = travel_reg;
        em_spd    = speed_reg;
        cnt_inc   = (count_reg == TICKS_MAX) ? count_reg : count_reg + 24'd1;
        case (item_reg.kind)
            KIND_START:
            begin
                fin_phase = PH_ACCEL;
                fin_count = '0;
                fin_clear = 1'b1;
                em_trv    = '0;
                em_spd    = '0;
            end
            KIND_STOP:
            begin
                if (phase_reg == PH_ACCEL || phase_reg == PH_CRUISE)
                begin
                    fin_phase = PH_DECEL;
                    fin_count = '0;
                end
            end
            KIND_TICK:
            begin
                if (phase_reg == PH_STOP)
                begin
                    fin_clear = 1'b1;
                    em_trv    = '0;
                    em_spd    = '0;
                end
                else
                begin
                    fin_count = cnt_inc;
                    case (phase_reg)
                        PH_ACCEL:
                        begin
                            if (cnt_inc >= accel_ticks_reg)
                            begin
                                fin_phase = tri_reg ? PH_DECEL : PH_CRUISE;
                                fin_count = '0;
                            end
                        end
                        PH_CRUISE:
                        begin
                            if (cnt_inc >= cruise_ticks_reg)
                            begin
                                fin_phase = PH_DECEL;
                                fin_count = '0;
                            end
                        end
                        default:
                        begin
                            // The move ends: show the last setpoints, then clear.
                            if (cnt_inc >= decel_ticks_reg || speed_reg <= 32'sd0)
                            begin
                                fin_phase = PH_STOP;
                                fin_count = '0;
                                fin_done  = 1'b1;
                                fin_clear = 1'b1;
                            end
                        end
                    endcase
                end
            end
            default:
            begin
                fin_count = count_reg;
            end
        endcase
        em = emit(em_trv, em_spd, turn_reg, rev_reg);
    end

    // Sequencer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            issued_reg       <= 1'b0;
            item_reg         <= '0;
            phase_reg        <= PH_STOP;
            speed_reg        <= '0;
            travel_reg       <= '0;
            accel_ticks_reg  <= '0;
            cruise_ticks_reg <= '0;
            decel_ticks_reg  <= '0;
            count_reg        <= '0;
            tri_reg          <= 1'b0;
            rev_reg          <= 1'b0;
            turn_reg         <= 1'b0;
            a_reg            <= '0;
            d_reg            <= '0;
            v_reg            <= '0;
            len_reg          <= '0;
            v2_reg           <= '0;
            ramp_reg         <= '0;
            prod_reg         <= '0;
            vp_reg           <= '0;
            rm_lo_reg        <= '0;
            out_valid_reg    <= 1'b0;
            out_emit_reg     <= '0;
            out_phase_reg    <= PH_STOP;
            out_done_reg     <= 1'b0;
        end
        else
        begin
            // A popped result is dropped unless the next one is written this cycle.
            if (pop && state_reg != S_FIN)
            begin
                out_valid_reg <= 1'b0;
            end
            if (div_start || sq_start)
            begin
                issued_reg <= 1'b1;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (head.valid)
                    begin
                        item_reg <= head.item;
                        if (head.item.kind == KIND_START)
                        begin
                            state_reg <= S_LEN;
                        end
                        else if (head.item.kind == KIND_TICK && phase_reg != PH_STOP)
                        begin
                            state_reg <= S_SPD;
                        end
                        else
                        begin
                            state_reg <= S_FIN;
                        end
                    end
                end
                S_LEN:
                begin
                    a_reg    <= nz16(cfg.accel);
                    d_reg    <= nz16(cfg.decel);
                    v_reg    <= (item_reg.max_speed == 12'd0) ? 12'd1 : item_reg.max_speed;
                    rev_reg  <= item_reg.distance[15];
                    turn_reg <= item_reg.rotate;
                    len_reg  <= item_reg.rotate ? mag * cfg.arc : {mag, 16'd0};
                    v2_reg   <= {(((item_reg.max_speed == 12'd0) ? 24'd1 :
                                  item_reg.max_speed * item_reg.max_speed)), 16'd0};
                    state_reg <= S_R1;
                end
                S_R1:
                begin
                    if (issued_reg && div_done)
                    begin
                        ramp_reg   <= div_q[40:0];
                        issued_reg <= 1'b0;
                        state_reg  <= S_R2;
                    end
                end
                S_R2:
                begin
                    if (issued_reg && div_done)
                    begin
                        ramp_reg   <= ramp_reg + div_q[40:0];
                        issued_reg <= 1'b0;
                        state_reg  <= S_CMP;
                    end
                end
                S_CMP:
                begin
                    // A trapezoid when both ramps fit in the move, else a triangle.
                    tri_reg   <= !(ramp_reg < {9'd0, len_reg});
                    state_reg <= (ramp_reg < {9'd0, len_reg}) ? S_T1 : S_M1;
                end
                S_T1:
                begin
                    if (issued_reg && div_done)
                    begin
                        accel_ticks_reg <= q_sat;
                        issued_reg      <= 1'b0;
                        state_reg       <= S_T2;
                    end
                end
                S_T2:
                begin
                    if (issued_reg && div_done)
                    begin
                        decel_ticks_reg <= q_sat;
                        issued_reg      <= 1'b0;
                        state_reg       <= S_T3;
                    end
                end
                S_T3:
                begin
                    if (issued_reg && div_done)
                    begin
                        cruise_ticks_reg <= q_sat;
                        issued_reg       <= 1'b0;
                        state_reg        <= S_FIN;
                    end
                end
                S_M1:
                begin
                    prod_reg  <= 64'(len_reg * a_reg);
                    state_reg <= S_M2;
                end
                S_M2:
                begin
                    prod_reg  <= {prod_full[62:0], 1'b0};
                    state_reg <= S_Q;
                end
                S_Q:
                begin
                    if (issued_reg && div_done)
                    begin
                        prod_reg   <= div_q;
                        issued_reg <= 1'b0;
                        state_reg  <= S_SQ;
                    end
                end
                S_SQ:
                begin
                    if (issued_reg && sq_done)
                    begin
                        vp_reg     <= sq_root;
                        issued_reg <= 1'b0;
                        state_reg  <= S_A;
                    end
                end
                S_A:
                begin
                    if (issued_reg && div_done)
                    begin
                        accel_ticks_reg <= q_sat;
                        issued_reg      <= 1'b0;
                        state_reg       <= S_D;
                    end
                end
                S_D:
                begin
                    if (issued_reg && div_done)
                    begin
                        decel_ticks_reg  <= q_sat;
                        cruise_ticks_reg <= '0;
                        issued_reg       <= 1'b0;
                        state_reg        <= S_FIN;
                    end
                end
                S_SPD:
                begin
                    if (!issued_reg)
                    begin
                        rm_lo_reg  <= rm_prod;
                        issued_reg <= 1'b1;
                    end
                    else
                    begin
                        if (phase_reg != PH_CRUISE)
                        begin
                            speed_reg <= spd_new;
                        end
                        issued_reg <= 1'b0;
                        state_reg  <= S_TRV;
                    end
                end
                S_TRV:
                begin
                    if (!issued_reg)
                    begin
                        rm_lo_reg  <= rm_prod;
                        issued_reg <= 1'b1;
                    end
                    else
                    begin
                        travel_reg <= trv_new;
                        issued_reg <= 1'b0;
                        state_reg  <= S_FIN;
                    end
                end
                S_FIN:
                begin
                    if (out_free)
                    begin
                        phase_reg     <= fin_phase;
                        count_reg     <= fin_count;
                        out_valid_reg <= 1'b1;
                        out_emit_reg  <= em;
                        out_phase_reg <= fin_phase;
                        out_done_reg  <= fin_done;
                        if (fin_clear)
                        begin
                            speed_reg  <= '0;
                            travel_reg <= '0;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign empty          = !out_valid_reg;
    assign left_setpoint  = out_emit_reg.left;
    assign right_setpoint = out_emit_reg.right;
    assign phase          = out_phase_reg;
    assign speed_now      = out_emit_reg.speed;
    assign move_done      = out_done_reg;

endmodule

// ===== design/trapezoid_motion_profile.sv =====
// Top level of the trapezoid motion profile generator: configuration registers and wiring.
// Each item pushed gives exactly one result, in order. Items wait in a two-entry queue and
// are carried out one at a time by a sequencer that shares one bit-serial divider and one
// bit-serial square root unit. A start runs five divisions for a trapezoidal move and five
// divisions and the square root for a triangular one; a tick during a move does its two
// divisions by the tick rate as a reciprocal multiply in two 16-bit halves each; a tick
// while stopped, a stop or an unknown opcode goes straight to the result register. The
// result register lets the next item start while a result still waits to be popped.
module trapezoid_motion_profile #(
    parameter int TICK_HZ = tmprof_pkg::TICK_HZ_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [1:0]         opcode,
    input  logic signed [15:0] distance,
    input  logic [11:0]        max_speed_mm_s,
    input  logic               rotate,
    output logic               empty,
    input  logic               pop,
    output logic signed [23:0] left_setpoint,
    output logic signed [23:0] right_setpoint,
    output logic [1:0]         phase,
    output logic [11:0]        speed_now,
    output logic               move_done,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data
);
    import tmprof_pkg::*;

    cfg_t   cfg_reg;
    qhead_t head;
    logic   head_pop;

    assign cfg_ready = 1'b1;

    // Configuration registers; writes to unused indexes are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.accel <= 16'd1000;
            cfg_reg.decel <= 16'd1000;
            cfg_reg.arc   <= 16'd1310;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_ACCEL: cfg_reg.accel <= cfg_data;
                CFG_DECEL: cfg_reg.decel <= cfg_data;
                CFG_ARC:   cfg_reg.arc   <= cfg_data;
                default:   cfg_reg       <= cfg_reg;
            endcase
        end
    end

    tmprof_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .opcode         (opcode),
        .distance       (distance),
        .max_speed_mm_s (max_speed_mm_s),
        .rotate         (rotate),
        .head           (head),
        .head_pop       (head_pop)
    );

    tmprof_back #(
        .TICK_HZ (TICK_HZ)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .head           (head),
        .head_pop       (head_pop),
        .empty          (empty),
        .pop            (pop),
        .left_setpoint  (left_setpoint),
        .right_setpoint (right_setpoint),
        .phase          (phase),
        .speed_now      (speed_now),
        .move_done      (move_done)
    );

endmodule
